>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are sampled on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/stdisp_pkg.sv
// ----------------------------------------------------------------------------
// stdisp_pkg
// Shared codes and controller/datapath interface types for the subscriber
// table dispatcher.
// ----------------------------------------------------------------------------
package stdisp_pkg;

    localparam logic [1:0] FUNC_SUB   = 2'd0;
    localparam logic [1:0] FUNC_UNSUB = 2'd1;
    localparam logic [1:0] FUNC_PUSH  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    // Kind of result loaded into the output register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_SUB_OK,
        EMIT_FULL,
        EMIT_UNSUB,
        EMIT_NOMEM,
        EMIT_TOPIC,
        EMIT_QUEUE
    } t_emit;

    typedef struct packed {
        logic  cap_id;        // capture sink id of accepted transaction
        logic  idx_clear;     // scan index to slot 0
        logic  idx_load_rp;   // scan index to round pointer
        logic  idx_inc;       // scan index to next slot, wrapping
        logic  sub_write;     // store id at scan index, mark used
        logic  unsub_check;   // drop slot at scan index if it holds the id
        logic  clear_removed;
        logic  emitted_clear;
        logic  emitted_inc;
        logic  rp_set_next;   // round pointer just past scan index
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic used_here;
        logic idx_last;
        logic cnt_zero;
        logic cnt_full;
        logic out_free;
        logic topic_last;
        logic queue_mode;
    } t_stat;

endpackage

>>> src/stdisp_dp.sv
// ----------------------------------------------------------------------------
// stdisp_dp
// Datapath: sink id memory, used bits, member count, round pointer, scan
// index and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stdisp_dp
    import stdisp_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int SINK_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [SINK_BITS-1:0]         i_sink_id,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_data,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [SINK_BITS-1:0]         o_target_sink,
    output logic                         o_target_valid,
    output logic                         o_last,
    output logic                         o_emptied,
    output logic [$clog2(SLOTS+1)-1:0]   o_member_total
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SINK_BITS-1:0] r_sink_mem [SLOTS];
    logic [SINK_BITS-1:0] r_rd;
    logic [SINK_BITS-1:0] r_id;
    logic [SLOTS-1:0]     r_used;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_emitted;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_rp;
    logic                 r_removed;
    logic                 r_kind;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [SINK_BITS-1:0] r_target_sink;
    logic                 r_target_valid;
    logic                 r_last;
    logic                 r_emptied;
    logic [CW-1:0]        r_member_total;

    logic                 idx_last;
    logic [IW-1:0]        idx_next;
    logic                 hit;
    logic                 topic_last;
    logic                 out_free;
    logic                 unsub_empty;

    assign idx_last    = (r_idx == IW'(SLOTS - 1));
    assign idx_next    = idx_last ? '0 : r_idx + IW'(1);
    assign hit         = r_used[r_idx] && (r_rd == r_id);
    assign topic_last  = ((r_emitted + CW'(1)) == r_count);
    assign out_free    = !r_out_valid || i_out_ready;
    assign unsub_empty = r_removed && (r_count == '0);

    always_comb begin
        o_stat.used_here  = r_used[r_idx];
        o_stat.idx_last   = idx_last;
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.cnt_full   = (r_count == CW'(SLOTS));
        o_stat.out_free   = out_free;
        o_stat.topic_last = topic_last;
        o_stat.queue_mode = r_kind;
    end

    // Sink id memory: one write port, one registered read port at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_write) begin
            r_sink_mem[r_idx] <= r_id;
        end
        r_rd <= r_sink_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_id) begin
            r_id <= i_sink_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_count   <= '0;
            r_emitted <= '0;
            r_idx     <= '0;
            r_rp      <= '0;
            r_removed <= 1'b0;
            r_kind    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= i_cfg_data;
            end

            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_load_rp) begin
                r_idx <= r_rp;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_next;
            end

            if (i_cmd.sub_write) begin
                r_used[r_idx] <= 1'b1;
                r_count       <= r_count + CW'(1);
            end else if (i_cmd.unsub_check && hit) begin
                r_used[r_idx] <= 1'b0;
                r_count       <= r_count - CW'(1);
            end

            if (i_cmd.clear_removed) begin
                r_removed <= 1'b0;
            end else if (i_cmd.unsub_check && hit) begin
                r_removed <= 1'b1;
            end

            if (i_cmd.emitted_clear) begin
                r_emitted <= '0;
            end else if (i_cmd.emitted_inc) begin
                r_emitted <= r_emitted + CW'(1);
            end

            if (i_cmd.rp_set_next) begin
                r_rp <= idx_next;
            end else if (i_cmd.emit == EMIT_UNSUB && unsub_empty) begin
                r_rp <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EMIT_NONE) begin
            r_member_total <= r_count;
            r_status       <= ST_OK;
            r_target_sink  <= '0;
            r_target_valid <= 1'b0;
            r_last         <= 1'b1;
            r_emptied      <= 1'b0;
            case (i_cmd.emit)
                EMIT_FULL:  r_status  <= ST_FULL;
                EMIT_NOMEM: r_status  <= ST_NOMEM;
                EMIT_UNSUB: r_emptied <= unsub_empty;
                EMIT_TOPIC: begin
                    r_target_sink  <= r_rd;
                    r_target_valid <= 1'b1;
                    r_last         <= topic_last;
                end
                EMIT_QUEUE: begin
                    r_target_sink  <= r_rd;
                    r_target_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_target_sink  = r_target_sink;
    assign o_target_valid = r_target_valid;
    assign o_last         = r_last;
    assign o_emptied      = r_emptied;
    assign o_member_total = r_member_total;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(SLOTS), "member count above slot total")
    `ASSERT_ALWAYS(a_emitted_bound, r_emitted <= r_count, "topic results exceed members")
    `ASSERT_NEXT(a_sub_count, i_cmd.sub_write, r_count == $past(r_count) + CW'(1), "subscribe did not count")
    `ASSERT_NEXT(a_no_overwrite, i_cmd.emit != EMIT_NONE, r_out_valid, "result register not loaded")

endmodule

>>> src/stdisp_ctrl.sv
// ----------------------------------------------------------------------------
// stdisp_ctrl
// Sequencer: decodes the accepted transaction and walks the slot table slot
// by slot, issuing datapath commands; a stalled output holds the walk.
// ----------------------------------------------------------------------------
module stdisp_ctrl
    import stdisp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB_SCAN,
        S_SUB_EMIT,
        S_FULL_EMIT,
        S_UN_SCAN,
        S_UN_CMP,
        S_UN_EMIT,
        S_NOMEM_EMIT,
        S_TOP_SCAN,
        S_TOP_EMIT,
        S_Q_SCAN,
        S_Q_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = EMIT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_id = 1'b1;
                    case (i_func)
                        FUNC_SUB: begin
                            o_cmd.idx_clear = 1'b1;
                            n_state = i_stat.cnt_full ? S_FULL_EMIT : S_SUB_SCAN;
                        end
                        FUNC_UNSUB: begin
                            o_cmd.idx_clear     = 1'b1;
                            o_cmd.clear_removed = 1'b1;
                            n_state = S_UN_SCAN;
                        end
                        FUNC_PUSH: begin
                            if (i_stat.cnt_zero) begin
                                n_state = S_NOMEM_EMIT;
                            end else if (i_stat.queue_mode) begin
                                o_cmd.idx_load_rp = 1'b1;
                                n_state = S_Q_SCAN;
                            end else begin
                                o_cmd.idx_clear     = 1'b1;
                                o_cmd.emitted_clear = 1'b1;
                                n_state = S_TOP_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // count below capacity guarantees a free slot before the end
            S_SUB_SCAN: begin
                if (!i_stat.used_here) begin
                    o_cmd.sub_write = 1'b1;
                    n_state = S_SUB_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SUB_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_SUB_OK;
                    n_state = S_IDLE;
                end
            end
            S_FULL_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_FULL;
                    n_state = S_IDLE;
                end
            end
            S_UN_SCAN: begin
                if (i_stat.used_here) begin
                    n_state = S_UN_CMP;
                end else if (i_stat.idx_last) begin
                    n_state = S_UN_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            // memory data for the scan index is valid here
            S_UN_CMP: begin
                o_cmd.unsub_check = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_UN_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_UN_SCAN;
                end
            end
            S_UN_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_UNSUB;
                    n_state = S_IDLE;
                end
            end
            S_NOMEM_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_NOMEM;
                    n_state = S_IDLE;
                end
            end
            S_TOP_SCAN: begin
                if (i_stat.used_here) begin
                    n_state = S_TOP_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TOP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = EMIT_TOPIC;
                    o_cmd.emitted_inc = 1'b1;
                    if (i_stat.topic_last) begin
                        // leave the counter at zero so it never exceeds a later count
                        o_cmd.emitted_clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_TOP_SCAN;
                    end
                end
            end
            S_Q_SCAN: begin
                if (i_stat.used_here) begin
                    n_state = S_Q_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_Q_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = EMIT_QUEUE;
                    o_cmd.rp_set_next = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/subscriber_table_dispatch.sv
// Subscribe scans from slot 0 to the first free slot; table full or empty push answers without a scan;
//   unsubscribe scans every slot, comparing each occupied one; queue push scans from the round pointer.
// Topic push: one result per member, scanning past empty slots between results.
// Throughput: one transaction at a time; input ready again the cycle after the last result
//   is loaded, and a stalled output holds the sequencer.
// Synchronous active-low reset clears used bits, count, round pointer, mode.
// ----------------------------------------------------------------------------
// subscriber_table_dispatch
// Subscriber table with topic broadcast and round-robin queue dispatch.
// ----------------------------------------------------------------------------
module subscriber_table_dispatch
    import stdisp_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int SINK_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_func,
    input  logic [SINK_BITS-1:0]         i_sink_id,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [SINK_BITS-1:0]         o_target_sink,
    output logic                         o_target_valid,
    output logic                         o_last,
    output logic                         o_emptied,
    output logic [$clog2(SLOTS+1)-1:0]   o_member_total
);

    t_cmd  cmd;
    t_stat stat;

    stdisp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stdisp_dp #(
        .SLOTS     (SLOTS),
        .SINK_BITS (SINK_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sink_id      (i_sink_id),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_target_sink  (o_target_sink),
        .o_target_valid (o_target_valid),
        .o_last         (o_last),
        .o_emptied      (o_emptied),
        .o_member_total (o_member_total)
    );

endmodule
